FILE: hw/rtl/tws_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Text window scroll engine package
// Command codes, register indexes, reset values and the window config type.
// ----------------------------------------------------------------------------
package tws_pkg;

	localparam int MAX_COLUMNS_DEF = 128;
	localparam int MAX_ROWS_DEF    = 64;

	localparam logic [2:0] MODE_WRITE  = 3'd0;
	localparam logic [2:0] MODE_READ   = 3'd1;
	localparam logic [2:0] MODE_SCROLL = 3'd2;
	localparam logic [2:0] MODE_PAN    = 3'd3;
	localparam logic [2:0] MODE_INSERT = 3'd4;
	localparam logic [2:0] MODE_DELETE = 3'd5;

	localparam logic [1:0] CFG_COLUMNS = 2'd0;
	localparam logic [1:0] CFG_ROWS    = 2'd1;
	localparam logic [1:0] CFG_FILL    = 2'd2;

	localparam logic [7:0] COLUMNS_RST = 8'd80;
	localparam logic [6:0] ROWS_RST    = 7'd25;
	localparam logic [7:0] FILL_RST    = 8'd7;
	localparam logic [7:0] SPACE_CHAR  = 8'h20;

	// effective window geometry and blank attribute
	typedef struct packed {
		logic [7:0] cols;
		logic [6:0] rows;
		logic [7:0] fill;
	} cfg_t;

endpackage
`default_nettype wire

FILE: hw/rtl/text_window_scroll_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Text window scroll engine
// Text cell store with write, read, scroll, pan, insert line and delete line.
//
//   channel   signals                                  handshake
//   command   mode amount row column cell_data         start, taken when !busy
//   result    read_data changed status                 done, one cycle
//   config    cfg_index cfg_data                       cfg_we, no wait
//
// After reset the store is swept to zero, one cell per cycle, with busy high.
// Rejected, zero-distance and unused commands end at decode; a write adds the
// multiply steps and a store access; a read also registers its data. Scroll,
// pan, insert and delete walk the affected lines, one cell copied or blanked
// per cycle by the single write port. done pulses for one cycle; the receiver
// cannot stall it.
// ----------------------------------------------------------------------------
module text_window_scroll_engine
	import tws_pkg::*;
#(
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  mode,
	input  wire logic [7:0]  amount,
	input  wire logic [5:0]  row,
	input  wire logic [6:0]  column,
	input  wire logic [15:0] cell_data,
	output logic             done,
	output logic      [15:0] read_data,
	output logic             changed,
	output logic             status,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);

	localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
	localparam int AW    = $clog2(DEPTH);

	cfg_t          cfg;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [15:0]   mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [15:0]   mem_rdata;

	tws_cfg #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tws_ctrl #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS),
		.DEPTH       (DEPTH),
		.AW          (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.start     (start),
		.mode      (mode),
		.amount    (amount),
		.row       (row),
		.column    (column),
		.cell_data (cell_data),
		.busy      (busy),
		.done      (done),
		.read_data (read_data),
		.changed   (changed),
		.status    (status),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	tws_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// a result only ever completes a command, so the sequencer is back at rest
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done raised while busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted item did not occupy the sequencer");

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status) |-> (!changed && (read_data == 16'd0)))
		else $error("rejected command reported a change or data");

endmodule
`default_nettype wire

FILE: hw/rtl/tws_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Window configuration registers
// Holds width, height and fill attribute; clamps geometry to the store size.
// ----------------------------------------------------------------------------
module tws_cfg
	import tws_pkg::*;
#(
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	output cfg_t            cfg
);

	localparam logic [8:0] COL_LIM = 9'(MAX_COLUMNS);
	localparam logic [7:0] ROW_LIM = 8'(MAX_ROWS);

	logic [7:0] cols_q;
	logic [6:0] rows_q;
	logic [7:0] fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= COLUMNS_RST;
			rows_q <= ROWS_RST;
			fill_q <= FILL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_COLUMNS: cols_q <= cfg_data;
				CFG_ROWS:    rows_q <= cfg_data[6:0];
				CFG_FILL:    fill_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// zero acts as one, anything past the store acts as the store limit
	always_comb begin
		if (cols_q == 8'd0)
			cfg.cols = 8'd1;
		else if ({1'b0, cols_q} > COL_LIM)
			cfg.cols = COL_LIM[7:0];
		else
			cfg.cols = cols_q;

		if (rows_q == 7'd0)
			cfg.rows = 7'd1;
		else if ({1'b0, rows_q} > ROW_LIM)
			cfg.rows = ROW_LIM[6:0];
		else
			cfg.rows = rows_q;

		cfg.fill = fill_q;
	end

endmodule
`default_nettype wire

FILE: hw/rtl/tws_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cell store
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module tws_ram
	import tws_pkg::*;
#(
	parameter int DEPTH = MAX_COLUMNS_DEF * MAX_ROWS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [15:0]   wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [15:0]   rdata
);

	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

FILE: hw/rtl/tws_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Command sequencer
// Decodes a command, forms addresses with one shared multiplier, then accesses
// one cell or walks the affected cells one per cycle, copying or blanking each.
// ----------------------------------------------------------------------------
module tws_ctrl
	import tws_pkg::*;
#(
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = MAX_ROWS_DEF,
	parameter int DEPTH       = MAX_COLUMNS * MAX_ROWS,
	parameter int AW          = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cfg_t          cfg,
	input  wire logic          start,
	input  wire logic [2:0]    mode,
	input  wire logic [7:0]    amount,
	input  wire logic [5:0]    row,
	input  wire logic [6:0]    column,
	input  wire logic [15:0]   cell_data,
	output logic               busy,
	output logic               done,
	output logic      [15:0]   read_data,
	output logic               changed,
	output logic               status,
	output logic               mem_we,
	output logic      [AW-1:0] mem_waddr,
	output logic      [15:0]   mem_wdata,
	output logic               mem_re,
	output logic      [AW-1:0] mem_raddr,
	input  wire logic [15:0]   mem_rdata
);

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_DEC  = 3'd2;
	localparam logic [2:0] ST_MUL0 = 3'd3;
	localparam logic [2:0] ST_MUL1 = 3'd4;
	localparam logic [2:0] ST_RUN  = 3'd5;
	localparam logic [2:0] ST_ACC  = 3'd6;
	localparam logic [2:0] ST_RDW  = 3'd7;

	localparam logic [1:0] K_FINISH = 2'd0;
	localparam logic [1:0] K_ACCESS = 2'd1;
	localparam logic [1:0] K_SWEEP  = 2'd2;

	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

	logic [2:0]    state_q;
	logic [AW-1:0] addr_q;
	logic          done_q;
	logic          wr_s1;

	// command fields
	logic [2:0]  mode_q;
	logic [7:0]  amount_q;
	logic [5:0]  row_q;
	logic [6:0]  column_q;
	logic [15:0] data_q;

	// sweep setup
	logic          access_q;
	logic          desc_q;
	logic          sel_col_q;
	logic          sub_q;
	logic [7:0]    lo_q;
	logic [7:0]    hi_q;
	logic [7:0]    ma_q;
	logic [7:0]    mb_q;
	logic          mb_w_q;
	logic [6:0]    r_q;
	logic [6:0]    r_end_q;
	logic [7:0]    c_q;
	logic [15:0]   prod_q;
	logic [AW-1:0] waddr_s1;
	logic          copy_s1;

	logic [15:0] read_data_q;
	logic        changed_q;
	logic        status_q;

	// decode results
	logic [1:0] d_kind;
	logic       d_status;
	logic       d_desc;
	logic       d_sel_col;
	logic       d_sub;
	logic [7:0] d_lo;
	logic [7:0] d_hi;
	logic [7:0] d_ma;
	logic [7:0] d_mb;
	logic       d_mb_w;
	logic [6:0] d_r_first;
	logic [6:0] d_r_end;
	logic [7:0] mag;
	logic       row_err;
	logic       col_err;

	logic [7:0]    w;
	logic [6:0]    h;
	logic [7:0]    w_m1;
	logic [7:0]    mul_a;
	logic [7:0]    mul_b;
	logic [15:0]   prod;
	logic [7:0]    cmp_val;
	logic          copy;
	logic          last;
	logic [AW-1:0] src;
	logic [AW-1:0] off;
	logic [15:0]   blank;
	logic          is_read;

	assign w       = cfg.cols;
	assign h       = cfg.rows;
	assign w_m1    = w - 8'd1;
	assign blank   = {cfg.fill, SPACE_CHAR};
	assign is_read = (mode_q == MODE_READ);

	always_comb begin
		mag       = amount_q[7] ? (~amount_q + 8'd1) : amount_q;
		row_err   = ({1'b0, row_q} >= h);
		col_err   = ({1'b0, column_q} >= w);
		d_kind    = K_FINISH;
		d_status  = 1'b0;
		d_desc    = 1'b0;
		d_sel_col = 1'b0;
		d_sub     = 1'b0;
		d_lo      = 8'd0;
		d_hi      = 8'd0;
		d_mb      = mag;
		d_mb_w    = 1'b1;
		d_r_first = 7'd0;
		d_r_end   = h - 7'd1;
		case (mode_q)
			MODE_WRITE, MODE_READ: begin
				if (row_err || col_err)
					d_status = 1'b1;
				else
					d_kind = K_ACCESS;
			end
			MODE_SCROLL: begin
				if (mag != 8'd0) begin
					d_kind = K_SWEEP;
					// a distance of the full height or more leaves hi at zero: all blank
					if (mag < {1'b0, h}) begin
						if (!amount_q[7]) begin
							d_hi = {1'b0, h} - mag;
						end else begin
							d_desc  = 1'b1;
							d_sub   = 1'b1;
							d_lo    = mag;
							d_hi    = {1'b0, h};
							d_r_end = 7'd0;
						end
					end
				end
			end
			MODE_PAN: begin
				if (mag != 8'd0) begin
					d_kind    = K_SWEEP;
					d_sel_col = 1'b1;
					d_mb_w    = 1'b0;
					if (mag < w) begin
						if (!amount_q[7]) begin
							d_hi = w - mag;
						end else begin
							d_desc  = 1'b1;
							d_sub   = 1'b1;
							d_lo    = mag;
							d_hi    = w;
							d_r_end = 7'd0;
						end
					end
				end
			end
			MODE_INSERT: begin
				if (row_err) begin
					d_status = 1'b1;
				end else begin
					d_kind  = K_SWEEP;
					d_desc  = 1'b1;
					d_sub   = 1'b1;
					d_lo    = {2'b00, row_q} + 8'd1;
					d_hi    = {1'b0, h};
					d_mb    = 8'd1;
					d_r_end = {1'b0, row_q};
				end
			end
			MODE_DELETE: begin
				if (row_err) begin
					d_status = 1'b1;
				end else begin
					d_kind    = K_SWEEP;
					d_lo      = {2'b00, row_q};
					d_hi      = {1'b0, h} - 8'd1;
					d_mb      = 8'd1;
					d_r_first = {1'b0, row_q};
				end
			end
			default: ;
		endcase
		// first address: top of the run, or one past the bottom for a descending run
		if (d_desc)
			d_ma = {1'b0, h};
		else if (d_kind == K_SWEEP)
			d_ma = {1'b0, d_r_first};
		else
			d_ma = {2'b00, row_q};
	end

	// shared multiplier
	assign mul_a = (state_q == ST_MUL0) ? ma_q : mb_q;
	assign mul_b = ((state_q == ST_MUL0) || mb_w_q) ? w : 8'd1;
	assign prod  = 16'(mul_a) * 16'(mul_b);

	// sweep step
	assign off     = prod_q[AW-1:0];
	assign src     = sub_q ? (addr_q - off) : (addr_q + off);
	assign cmp_val = sel_col_q ? c_q : {1'b0, r_q};
	assign copy    = (cmp_val >= lo_q) && (cmp_val < hi_q);
	assign last    = (r_q == r_end_q) && (desc_q ? (c_q == 8'd0) : (c_q == w_m1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			addr_q  <= '0;
			done_q  <= 1'b0;
			wr_s1   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			wr_s1  <= 1'b0;
			case (state_q)
				ST_CLR: begin
					addr_q <= addr_q + AW'(1);
					if (addr_q == LAST_ADDR)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (start)
						state_q <= ST_DEC;
				end
				ST_DEC: begin
					if (d_kind == K_FINISH) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= ST_MUL0;
					end
				end
				ST_MUL0: state_q <= ST_MUL1;
				ST_MUL1: begin
					if (access_q)
						addr_q <= prod_q[AW-1:0] + AW'(column_q);
					else if (desc_q)
						addr_q <= prod_q[AW-1:0] - AW'(1);
					else
						addr_q <= prod_q[AW-1:0];
					state_q <= access_q ? ST_ACC : ST_RUN;
				end
				ST_RUN: begin
					wr_s1  <= 1'b1;
					addr_q <= desc_q ? (addr_q - AW'(1)) : (addr_q + AW'(1));
					if (last) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				ST_ACC: begin
					if (is_read) begin
						state_q <= ST_RDW;
					end else begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				ST_RDW: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					mode_q   <= mode;
					amount_q <= amount;
					row_q    <= row;
					column_q <= column;
					data_q   <= cell_data;
				end
			end
			ST_DEC: begin
				access_q    <= (d_kind == K_ACCESS);
				desc_q      <= d_desc;
				sel_col_q   <= d_sel_col;
				sub_q       <= d_sub;
				lo_q        <= d_lo;
				hi_q        <= d_hi;
				ma_q        <= d_ma;
				mb_q        <= d_mb;
				mb_w_q      <= d_mb_w;
				r_q         <= d_desc ? (h - 7'd1) : d_r_first;
				c_q         <= d_desc ? w_m1 : 8'd0;
				r_end_q     <= d_r_end;
				status_q    <= d_status;
				read_data_q <= 16'd0;
				changed_q   <= (d_kind == K_SWEEP) ||
				               ((d_kind == K_ACCESS) && (mode_q == MODE_WRITE));
			end
			ST_MUL0: prod_q <= prod;
			ST_MUL1: prod_q <= prod;
			ST_RUN: begin
				waddr_s1 <= addr_q;
				copy_s1  <= copy;
				if (desc_q) begin
					if (c_q == 8'd0) begin
						c_q <= w_m1;
						r_q <= r_q - 7'd1;
					end else begin
						c_q <= c_q - 8'd1;
					end
				end else begin
					if (c_q == w_m1) begin
						c_q <= 8'd0;
						r_q <= r_q + 7'd1;
					end else begin
						c_q <= c_q + 8'd1;
					end
				end
			end
			ST_RDW: read_data_q <= mem_rdata;
			default: ;
		endcase
	end

	// store ports: clearing pass, delayed sweep write or single-cell write, and reads
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = 16'd0;
		mem_re    = 1'b0;
		mem_raddr = addr_q;
		if (state_q == ST_CLR) begin
			mem_we = 1'b1;
		end else if (wr_s1) begin
			mem_we    = 1'b1;
			mem_waddr = waddr_s1;
			mem_wdata = copy_s1 ? mem_rdata : blank;
		end else if ((state_q == ST_ACC) && !is_read) begin
			mem_we    = 1'b1;
			mem_wdata = data_q;
		end
		if ((state_q == ST_RUN) && copy) begin
			mem_re    = 1'b1;
			mem_raddr = src;
		end else if ((state_q == ST_ACC) && is_read) begin
			mem_re = 1'b1;
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign read_data = read_data_q;
	assign changed   = changed_q;
	assign status    = status_q;

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text window scroll engine testbench
// Drives write, read, scroll, pan, insert, delete and unused commands through
// several window geometries and fill attributes. A local model of the cell
// store predicts each result, and the monitor compares every done pulse with it.
// ----------------------------------------------------------------------------
module tb_top;
	import tws_pkg::*;

	localparam int          STORE_CELLS    = MAX_COLUMNS_DEF * MAX_ROWS_DEF;
	localparam logic [2:0]  MODE_UNUSED_LO = 3'd6;
	localparam logic [2:0]  MODE_UNUSED_HI = 3'd7;
	localparam int          SETTLE_CYCLES  = 4;
	localparam int          END_SETTLE     = 8300;
	localparam int          WATCHDOG_LIMIT = 40000;
	localparam int          REPORT_LIMIT   = 10;

	typedef enum logic [1:0] {ENTRY_CMD, ENTRY_CFG, ENTRY_HOLD} entry_kind_e;

	typedef struct {
		entry_kind_e kind;
		logic [2:0]  mode;
		logic [7:0]  amount;
		logic [5:0]  row;
		logic [6:0]  column;
		logic [15:0] cell_data;
		logic [1:0]  cfg_index;
		logic [7:0]  cfg_data;
	} entry_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic        changed;
		logic        status;
	} result_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        start     = 1'b0;
	logic [2:0]  mode      = '0;
	logic [7:0]  amount    = '0;
	logic [5:0]  row       = '0;
	logic [6:0]  column    = '0;
	logic [15:0] cell_data = '0;
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [7:0]  cfg_data  = '0;
	logic        busy;
	logic        done;
	logic [15:0] read_data;
	logic        changed;
	logic        status;

	text_window_scroll_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.mode      (mode),
		.amount    (amount),
		.row       (row),
		.column    (column),
		.cell_data (cell_data),
		.done      (done),
		.read_data (read_data),
		.changed   (changed),
		.status    (status),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// model of the store and registers
	logic [15:0] screen_cells [STORE_CELLS];
	logic [7:0]  reg_cols = COLUMNS_RST;
	logic [6:0]  reg_rows = ROWS_RST;
	logic [7:0]  reg_fill = FILL_RST;

	entry_t      pend_q[$];
	result_t     expected_q[$];
	int unsigned items_taken  = 0;
	int unsigned results_seen = 0;
	int unsigned idle_gap     = 0;
	int unsigned quiet_cycles = 0;
	int unsigned burst_left   = 0;
	int unsigned stall_cycles = 0;
	int          fail_count   = 0;
	int          plan_w;
	int          plan_h;

	function automatic int clamp_dim(int raw, int limit);
		if (raw == 0)
			return 1;
		if (raw > limit)
			return limit;
		return raw;
	endfunction

	function automatic logic [15:0] blank_cell();
		return {reg_fill, SPACE_CHAR};
	endfunction

	function automatic void copy_line(int dst, int src, int w);
		for (int c = 0; c < w; c++)
			screen_cells[dst * w + c] = screen_cells[src * w + c];
	endfunction

	function automatic void blank_line(int r, int w);
		for (int c = 0; c < w; c++)
			screen_cells[r * w + c] = blank_cell();
	endfunction

	function automatic void clear_window(int w, int h);
		for (int r = 0; r < h; r++)
			blank_line(r, w);
	endfunction

	function automatic result_t apply_command(logic [2:0] op, logic [7:0] distance,
			logic [5:0] line, logic [6:0] col, logic [15:0] value);
		result_t res;
		int      w, h, amt, mag, r, c, k;
		w   = clamp_dim(int'(reg_cols), MAX_COLUMNS_DEF);
		h   = clamp_dim(int'(reg_rows), MAX_ROWS_DEF);
		amt = int'($signed(distance));
		mag = (amt < 0) ? -amt : amt;
		r   = int'(line);
		c   = int'(col);
		res = '0;
		case (op)
			MODE_WRITE: begin
				if (r >= h || c >= w) begin
					res.status = 1'b1;
				end else begin
					screen_cells[r * w + c] = value;
					res.changed = 1'b1;
				end
			end
			MODE_READ: begin
				if (r >= h || c >= w)
					res.status = 1'b1;
				else
					res.read_data = screen_cells[r * w + c];
			end
			MODE_SCROLL: begin
				if (amt != 0) begin
					res.changed = 1'b1;
					if (mag >= h) begin
						clear_window(w, h);
					end else if (amt > 0) begin
						for (int y = 0; y + mag < h; y++)
							copy_line(y, y + mag, w);
						for (int y = h - mag; y < h; y++)
							blank_line(y, w);
					end else begin
						for (int y = h - 1; y >= mag; y--)
							copy_line(y, y - mag, w);
						for (int y = 0; y < mag; y++)
							blank_line(y, w);
					end
				end
			end
			MODE_PAN: begin
				if (amt != 0) begin
					res.changed = 1'b1;
					if (mag >= w) begin
						clear_window(w, h);
					end else begin
						for (int y = 0; y < h; y++) begin
							if (amt > 0) begin
								for (k = 0; k + mag < w; k++)
									screen_cells[y * w + k] = screen_cells[y * w + k + mag];
								for (k = w - mag; k < w; k++)
									screen_cells[y * w + k] = blank_cell();
							end else begin
								for (k = w - 1; k >= mag; k--)
									screen_cells[y * w + k] = screen_cells[y * w + k - mag];
								for (k = 0; k < mag; k++)
									screen_cells[y * w + k] = blank_cell();
							end
						end
					end
				end
			end
			MODE_INSERT: begin
				if (r >= h) begin
					res.status = 1'b1;
				end else begin
					for (int y = h - 1; y > r; y--)
						copy_line(y, y - 1, w);
					blank_line(r, w);
					res.changed = 1'b1;
				end
			end
			MODE_DELETE: begin
				if (r >= h) begin
					res.status = 1'b1;
				end else begin
					for (int y = r; y + 1 < h; y++)
						copy_line(y, y + 1, w);
					blank_line(h - 1, w);
					res.changed = 1'b1;
				end
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned p;
		if (burst_left != 0) begin
			burst_left--;
			return 0;
		end
		p = $urandom_range(0, 99);
		// now and then run a stretch of items back to back
		if (p < 8)
			burst_left = $urandom_range(5, 20);
		if (p < 55)
			return 0;
		if (p < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// item driver
	always @(posedge clk or negedge arst_n) begin : item_driver
		entry_t      head;
		logic        nx_start;
		logic        nx_we;
		int unsigned gap;
		if (!arst_n) begin
			start        <= 1'b0;
			cfg_we       <= 1'b0;
			idle_gap     <= 0;
			quiet_cycles <= 0;
		end else begin
			nx_start = start;
			nx_we    = 1'b0;
			if (start && !busy) begin
				expected_q.push_back(apply_command(mode, amount, row, column, cell_data));
				items_taken <= items_taken + 1;
				nx_start = 1'b0;
				gap = pick_gap();
				idle_gap <= gap;
				if (gap == 0 && pend_q.size() != 0 && pend_q[0].kind == ENTRY_CMD) begin
					head      = pend_q.pop_front();
					nx_start  = 1'b1;
					mode      <= head.mode;
					amount    <= head.amount;
					row       <= head.row;
					column    <= head.column;
					cell_data <= head.cell_data;
				end
			end else if (!start) begin
				if (idle_gap != 0) begin
					idle_gap <= idle_gap - 1;
				end else if (pend_q.size() != 0) begin
					if (pend_q[0].kind == ENTRY_CMD) begin
						head      = pend_q.pop_front();
						nx_start  = 1'b1;
						mode      <= head.mode;
						amount    <= head.amount;
						row       <= head.row;
						column    <= head.column;
						cell_data <= head.cell_data;
					end else if (items_taken == results_seen && !busy
							&& quiet_cycles >= SETTLE_CYCLES) begin
						// block is drained: apply the register write or release the hold
						head = pend_q.pop_front();
						if (head.kind == ENTRY_CFG) begin
							nx_we = 1'b1;
							cfg_index <= head.cfg_index;
							cfg_data  <= head.cfg_data;
							case (head.cfg_index)
								CFG_COLUMNS: reg_cols = head.cfg_data;
								CFG_ROWS:    reg_rows = head.cfg_data[6:0];
								CFG_FILL:    reg_fill = head.cfg_data;
								default: begin
								end
							endcase
						end
					end
				end
			end
			quiet_cycles <= (items_taken == results_seen && !busy && !start)
				? quiet_cycles + 1 : 0;
			start  <= nx_start;
			cfg_we <= nx_we;
		end
	end

	// result monitor
	always @(posedge clk) begin : result_monitor
		result_t want;
		if (arst_n && done) begin
			results_seen <= results_seen + 1;
			if (expected_q.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_LIMIT)
					$display("unexpected result: read_data %h changed %b status %b",
						read_data, changed, status);
			end else begin
				want = expected_q.pop_front();
				if (read_data !== want.read_data || changed !== want.changed
						|| status !== want.status) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("mismatch on result %0d: read_data %h/%h changed %b/%b status %b/%b (expected/actual)",
							results_seen, want.read_data, read_data, want.changed, changed,
							want.status, status);
				end
			end
		end
	end

	// watchdog on cycles with no traffic
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || cfg_we) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("text_window_scroll_engine verification failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic queue_cmd(logic [2:0] op, int distance, int r, int c, logic [15:0] value);
		entry_t e;
		e           = '{kind: ENTRY_CMD, default: '0};
		e.kind      = ENTRY_CMD;
		e.mode      = op;
		e.amount    = distance[7:0];
		e.row       = r[5:0];
		e.column    = c[6:0];
		e.cell_data = value;
		pend_q.push_back(e);
	endtask

	task automatic queue_cfg(logic [1:0] idx, int unsigned value);
		entry_t e;
		e           = '{kind: ENTRY_CFG, default: '0};
		e.kind      = ENTRY_CFG;
		e.cfg_index = idx;
		e.cfg_data  = value[7:0];
		pend_q.push_back(e);
		if (idx == CFG_COLUMNS)
			plan_w = clamp_dim(int'(value[7:0]), MAX_COLUMNS_DEF);
		else if (idx == CFG_ROWS)
			plan_h = clamp_dim(int'(value[6:0]), MAX_ROWS_DEF);
	endtask

	task automatic queue_hold();
		entry_t e;
		e      = '{kind: ENTRY_HOLD, default: '0};
		e.kind = ENTRY_HOLD;
		pend_q.push_back(e);
	endtask

	task automatic queue_random_cmd();
		int unsigned pick;
		logic [2:0]  op;
		int          lim, distance, r, c;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			op = MODE_WRITE;
		else if (pick < 58)
			op = MODE_READ;
		else if (pick < 68)
			op = MODE_SCROLL;
		else if (pick < 78)
			op = MODE_PAN;
		else if (pick < 86)
			op = MODE_INSERT;
		else if (pick < 94)
			op = MODE_DELETE;
		else
			op = $urandom_range(0, 1) ? MODE_UNUSED_HI : MODE_UNUSED_LO;
		lim = ((op == MODE_PAN) ? plan_w : plan_h) + 1;
		if (lim > 127)
			lim = 127;
		if ($urandom_range(0, 4) == 0)
			distance = int'($urandom_range(0, 255)) - 128;
		else
			distance = int'($urandom_range(0, 2 * lim)) - lim;
		r = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 63))
			: int'($urandom_range(0, plan_h - 1));
		c = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 127))
			: int'($urandom_range(0, plan_w - 1));
		queue_cmd(op, distance, r, c, 16'($urandom_range(0, 65535)));
	endtask

	initial begin
		int phase;
		int n;
		foreach (screen_cells[i])
			screen_cells[i] = '0;
		plan_w = clamp_dim(int'(COLUMNS_RST), MAX_COLUMNS_DEF);
		plan_h = clamp_dim(int'(ROWS_RST), MAX_ROWS_DEF);

		// reset geometry: 80 x 25, attribute 7
		queue_cmd(MODE_WRITE, 0, 0, 0, 16'hFFFF);
		queue_cmd(MODE_WRITE, 0, 24, 79, 16'h1234);
		queue_cmd(MODE_WRITE, 0, 12, 40, 16'h8001);
		queue_cmd(MODE_READ, 0, 0, 0, 16'h0000);
		queue_cmd(MODE_READ, 0, 24, 79, 16'h0000);
		queue_cmd(MODE_WRITE, 0, 25, 0, 16'hBEEF);
		queue_cmd(MODE_READ, 0, 0, 80, 16'h0000);
		queue_cmd(MODE_WRITE, 0, 63, 127, 16'hFFFF);
		queue_cmd(MODE_SCROLL, 0, 5, 5, 16'h0000);
		queue_cmd(MODE_PAN, 0, 0, 0, 16'h0000);
		queue_cmd(MODE_SCROLL, 1, 0, 0, 16'h0000);
		queue_cmd(MODE_READ, 0, 23, 79, 16'h0000);
		queue_cmd(MODE_SCROLL, -3, 0, 0, 16'h0000);
		queue_cmd(MODE_PAN, 2, 0, 0, 16'h0000);
		queue_cmd(MODE_PAN, -5, 0, 0, 16'h0000);
		queue_cmd(MODE_READ, 0, 14, 43, 16'h0000);
		queue_hold();
		queue_cmd(MODE_INSERT, 0, 0, 0, 16'h0000);
		queue_cmd(MODE_DELETE, 0, 24, 0, 16'h0000);
		queue_cmd(MODE_INSERT, 0, 25, 0, 16'h0000);
		queue_cmd(MODE_DELETE, 0, 63, 0, 16'h0000);
		queue_cmd(MODE_UNUSED_LO, -1, 63, 127, 16'hFFFF);
		queue_cmd(MODE_UNUSED_HI, 5, 1, 1, 16'h5555);
		queue_cmd(MODE_SCROLL, 127, 0, 0, 16'h0000);
		queue_cmd(MODE_PAN, -128, 0, 0, 16'h0000);
		queue_cmd(MODE_READ, 0, 3, 3, 16'h0000);

		// zero registers act as a one-cell window
		queue_cfg(CFG_COLUMNS, 0);
		queue_cfg(CFG_ROWS, 0);
		queue_cfg(CFG_FILL, 255);
		queue_cmd(MODE_WRITE, 0, 0, 0, 16'hA5A5);
		queue_cmd(MODE_READ, 0, 0, 0, 16'h0000);
		queue_cmd(MODE_WRITE, 0, 0, 1, 16'h1111);
		queue_cmd(MODE_SCROLL, 1, 0, 0, 16'h0000);
		queue_cmd(MODE_WRITE, 0, 0, 0, 16'h7E7E);
		queue_cmd(MODE_PAN, -1, 0, 0, 16'h0000);
		queue_cmd(MODE_INSERT, 0, 0, 0, 16'h0000);
		queue_cmd(MODE_DELETE, 0, 0, 0, 16'h0000);
		queue_cmd(MODE_READ, 0, 0, 0, 16'h0000);

		// oversize registers clamp to the full store
		queue_cfg(CFG_COLUMNS, 255);
		queue_cfg(CFG_ROWS, 127);
		queue_cfg(CFG_FILL, 0);
		queue_cmd(MODE_WRITE, 0, 63, 127, 16'hFFFF);
		queue_cmd(MODE_WRITE, 0, 0, 0, 16'h0001);
		queue_cmd(MODE_READ, 0, 63, 127, 16'h0000);
		queue_cmd(MODE_SCROLL, 1, 0, 0, 16'h0000);
		queue_cmd(MODE_READ, 0, 62, 127, 16'h0000);
		queue_cmd(MODE_PAN, -1, 0, 0, 16'h0000);
		queue_cmd(MODE_READ, 0, 62, 0, 16'h0000);
		queue_cmd(MODE_INSERT, 0, 63, 0, 16'h0000);
		queue_cmd(MODE_READ, 0, 63, 127, 16'h0000);

		// exact maximum width, one line
		queue_cfg(CFG_COLUMNS, 128);
		queue_cfg(CFG_ROWS, 1);
		queue_cfg(CFG_FILL, 8'h5A);
		queue_cmd(MODE_WRITE, 0, 0, 127, 16'hC3C3);
		queue_cmd(MODE_PAN, 100, 0, 0, 16'h0000);
		queue_cmd(MODE_READ, 0, 0, 27, 16'h0000);
		queue_cmd(MODE_PAN, -128, 0, 0, 16'h0000);
		queue_cmd(MODE_READ, 0, 0, 27, 16'h0000);

		// exact maximum height, one column
		queue_cfg(CFG_COLUMNS, 1);
		queue_cfg(CFG_ROWS, 64);
		queue_cmd(MODE_WRITE, 0, 63, 0, 16'h3C3C);
		queue_cmd(MODE_SCROLL, 63, 0, 0, 16'h0000);
		queue_cmd(MODE_READ, 0, 0, 0, 16'h0000);
		queue_cmd(MODE_SCROLL, -63, 0, 0, 16'h0000);
		queue_cmd(MODE_READ, 0, 63, 0, 16'h0000);

		// random commands over a series of small windows and one wide one
		for (phase = 0; phase < 7; phase++) begin
			queue_cfg(CFG_FILL, $urandom_range(0, 255));
			queue_cfg(CFG_COLUMNS, (phase == 3) ? $urandom_range(100, 128)
				: $urandom_range(1, 24));
			queue_cfg(CFG_ROWS, (phase == 3) ? $urandom_range(2, 4) : $urandom_range(1, 12));
			for (n = 0; n < 7; n++) begin
				if ($urandom_range(0, 29) == 0)
					queue_hold();
				queue_random_cmd();
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (pend_q.size() != 0 || start)
			@(posedge clk);
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (END_SETTLE) @(posedge clk);

		if (fail_count == 0 && expected_q.size() == 0) begin
			$display("text_window_scroll_engine verification clean");
		end else begin
			$display("text_window_scroll_engine verification failed");
		end
		$finish;
	end

endmodule
